// ===== hw/rtl/fps_pkg.sv =====
package fps_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int MAX_SAMPLES = 64;
  localparam int LANES       = 4;
  localparam int LANE_W      = $clog2(LANES);
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int BANK_DEPTH  = MAX_POINTS / LANES;
  localparam int ADDR_W      = $clog2(BANK_DEPTH);
  localparam int ROW_W       = ADDR_W + 1;
  localparam int COORD_W     = 16;
  localparam int PT_W        = 3 * COORD_W;
  localparam int DIST_W      = 34;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int SCNT_W      = 7;
  localparam int CFG_DATA_W  = 10;

  localparam logic [DIST_W-1:0] DIST_ONES = '1;

  typedef enum logic [0:0] {
    REG_SAMPLE_COUNT = 1'b0,
    REG_START_INDEX  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_EMIT,
    ST_FETCH,
    ST_FETCH_WAIT,
    ST_SWEEP,
    ST_DRAIN,
    ST_PICK
  } fps_state_e;

  // Per-lane control from the sequencer.
  typedef struct packed {
    logic              rd_en;   // read point and distance at rd_addr
    logic              sweep;   // the read belongs to a distance sweep
    logic [ADDR_W-1:0] rd_addr;
    logic              ld_we;   // store a new point, distance all ones
    logic              mk_we;   // mark an entry as selected
    logic [ADDR_W-1:0] wr_addr;
  } lane_ctl_t;

  // What one lane found in one sweep step.
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] score;
    logic [IDX_W-1:0]  idx;
  } cand_t;

endpackage

// ===== hw/rtl/farthest_point_sampler.sv =====
// Farthest point sampler. Points of one cloud stream in at one item per cycle
// and are stored in arrival order; the item with last_point set closes the
// cloud and starts selection. The block then returns min(point count, sample
// count) indices: first start_index, then each point whose distance to the
// nearest selected point is largest, lowest index on ties. A start index not
// below the point count gives a single item with start_error set. Four lanes
// each own one bank of the point and distance store and update four points
// per cycle; a merge stage keeps the running best. Each selection round after
// the first emits the previous index once the output is free, fetches the last
// selected point, sweeps the banks one row per cycle, drains the lane pipeline
// and picks the winner from the merge stage.
// Input is held off from the closing item until the final index is emitted.
// Configuration writes are accepted at any time but belong between clouds.
module farthest_point_sampler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [fps_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [fps_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [fps_pkg::COORD_W-1:0] coord_y_i,
  input  logic signed [fps_pkg::COORD_W-1:0] coord_z_i,
  input  logic                              last_point_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fps_pkg::IDX_W-1:0]         sample_index_o,
  output logic                              last_sample_o,
  output logic                              start_error_o
);
  import fps_pkg::*;

  fps_state_e          state_q, state_d;

  logic [SCNT_W-1:0]   sample_count_q;
  logic [IDX_W-1:0]    start_index_q;
  logic [CNT_W-1:0]    count_q;
  logic [IDX_W-1:0]    last_q;
  logic [SCNT_W-1:0]   k_q, round_q;
  logic [ADDR_W-1:0]   row_q, last_row_q;
  logic [1:0]          drain_q;
  logic [PT_W-1:0]     ref_q;
  logic [IDX_W-1:0]    emit_idx_q;
  logic                emit_last_q, emit_err_q;

  logic                out_valid_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic                out_last_q, out_err_q;

  logic                in_fire, cfg_fire, out_free;
  logic [SCNT_W-1:0]   k_sat;
  logic [CNT_W-1:0]    k_full;
  logic [ROW_W:0]      rows;
  logic                merge_clear;
  logic [IDX_W-1:0]    best_idx;

  lane_ctl_t           ctl [LANES];
  cand_t               cand [LANES];
  logic [PT_W-1:0]     lane_pt [LANES];
  logic [PT_W-1:0]     wr_pt;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign wr_pt       = {coord_z_i, coord_y_i, coord_x_i};

  // Effective sample count: zero reads as one, and the count saturates.
  always_comb begin
    k_sat = sample_count_q;
    if (sample_count_q == '0) begin
      k_sat = SCNT_W'(1);
    end else if (sample_count_q > SCNT_W'(MAX_SAMPLES)) begin
      k_sat = SCNT_W'(MAX_SAMPLES);
    end
    k_full = ({{(CNT_W-SCNT_W){1'b0}}, k_sat} < count_q) ?
             {{(CNT_W-SCNT_W){1'b0}}, k_sat} : count_q;
    rows   = (ROW_W+1)'(count_q) + (ROW_W+1)'(LANES - 1);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire && last_point_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK:      state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = emit_last_q ? ST_LOAD : ST_FETCH;
        end
      end
      ST_FETCH:      state_d = ST_FETCH_WAIT;
      ST_FETCH_WAIT: state_d = ST_SWEEP;
      ST_SWEEP: begin
        if (row_q == last_row_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_q == 2'd3) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK:       state_d = ST_EMIT;
      default:       state_d = ST_LOAD;
    endcase
  end

  // Outputs toward the lanes and the merge stage.
  always_comb begin
    in_ready_o  = 1'b0;
    merge_clear = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      ctl[l] = '0;
    end
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        for (int l = 0; l < LANES; l++) begin
          ctl[l].wr_addr = count_q[LANE_W +: ADDR_W];
          ctl[l].ld_we   = in_valid_i && (count_q < CNT_W'(MAX_POINTS))
                         && (count_q[LANE_W-1:0] == LANE_W'(l));
        end
      end
      ST_FETCH: begin
        for (int l = 0; l < LANES; l++) begin
          ctl[l].rd_addr = last_q[IDX_W-1:LANE_W];
          ctl[l].wr_addr = last_q[IDX_W-1:LANE_W];
          ctl[l].rd_en   = (last_q[LANE_W-1:0] == LANE_W'(l));
          ctl[l].mk_we   = (last_q[LANE_W-1:0] == LANE_W'(l));
        end
      end
      ST_FETCH_WAIT: merge_clear = 1'b1;
      ST_SWEEP: begin
        for (int l = 0; l < LANES; l++) begin
          ctl[l].rd_addr = row_q;
          ctl[l].rd_en   = 1'b1;
          ctl[l].sweep   = 1'b1;
        end
      end
      ST_CHECK, ST_EMIT, ST_DRAIN, ST_PICK: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_LOAD;
      sample_count_q <= SCNT_W'(1);
      start_index_q  <= '0;
      count_q        <= '0;
      last_q         <= '0;
      k_q            <= '0;
      round_q        <= '0;
      row_q          <= '0;
      last_row_q     <= '0;
      drain_q        <= '0;
      emit_last_q    <= 1'b0;
      emit_err_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        case (cfg_index_i)
          REG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[SCNT_W-1:0];
          REG_START_INDEX:  start_index_q  <= cfg_data_i[IDX_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (in_fire && (count_q < CNT_W'(MAX_POINTS))) begin
            count_q <= count_q + CNT_W'(1);
          end
        end
        ST_CHECK: begin
          // A point that closes a full store is dropped but still closes the cloud.
          if ({1'b0, start_index_q} >= count_q) begin
            emit_idx_q  <= '0;
            emit_last_q <= 1'b1;
            emit_err_q  <= 1'b1;
          end else begin
            emit_idx_q  <= start_index_q;
            emit_last_q <= (k_full == CNT_W'(1));
            emit_err_q  <= 1'b0;
          end
          last_q     <= start_index_q;
          k_q        <= k_full[SCNT_W-1:0];
          round_q    <= SCNT_W'(1);
          last_row_q <= ADDR_W'((rows >> LANE_W) - (ROW_W+1)'(1));
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= emit_idx_q;
            out_last_q  <= emit_last_q;
            out_err_q   <= emit_err_q;
            if (emit_last_q) begin
              count_q <= '0;
            end
          end
        end
        ST_FETCH_WAIT: begin
          ref_q <= lane_pt[last_q[LANE_W-1:0]];
          row_q <= '0;
        end
        ST_SWEEP: begin
          row_q   <= row_q + ADDR_W'(1);
          drain_q <= '0;
        end
        ST_DRAIN: drain_q <= drain_q + 2'd1;
        ST_PICK: begin
          last_q      <= best_idx;
          emit_idx_q  <= best_idx;
          emit_last_q <= (round_q + SCNT_W'(1) == k_q);
          emit_err_q  <= 1'b0;
          round_q     <= round_q + SCNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    fps_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .lane_id_i (LANE_W'(l)),
      .ctl_i     (ctl[l]),
      .wr_pt_i   (wr_pt),
      .ref_pt_i  (ref_q),
      .count_i   (count_q),
      .rd_pt_o   (lane_pt[l]),
      .cand_o    (cand[l])
    );
  end

  fps_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (merge_clear),
    .cand_i     (cand),
    .best_idx_o (best_idx)
  );

  assign out_valid_o    = out_valid_q;
  assign sample_index_o = out_idx_q;
  assign last_sample_o  = out_last_q;
  assign start_error_o  = out_err_q;

endmodule

// ===== hw/rtl/fps_lane.sv =====
module fps_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fps_pkg::LANE_W-1:0]    lane_id_i,
  input  fps_pkg::lane_ctl_t            ctl_i,
  input  logic [fps_pkg::PT_W-1:0]      wr_pt_i,
  input  logic [fps_pkg::PT_W-1:0]      ref_pt_i,
  input  logic [fps_pkg::CNT_W-1:0]     count_i,
  output logic [fps_pkg::PT_W-1:0]      rd_pt_o,
  output fps_pkg::cand_t                cand_o
);
  import fps_pkg::*;

  logic [PT_W-1:0]     pt_mem [BANK_DEPTH];
  logic [DIST_W:0]     dist_mem [BANK_DEPTH];   // {selected, distance}
  logic [PT_W-1:0]     pt_rd_q;
  logic [DIST_W:0]     dist_rd_q;

  logic                s1_v_q, s2_v_q, s3_v_q;
  logic [ADDR_W-1:0]   s1_a_q, s2_a_q, s3_a_q;
  logic [SQ_W-1:0]     sq_d [3];
  logic [SQ_W-1:0]     sq_q [3];
  logic [DIST_W:0]     s2_old_q;
  logic [DIST_W-1:0]   sum_d, nd_d;
  logic [DIST_W-1:0]   s3_nd_q;
  logic                s3_sel_q;

  logic                cand_v;
  logic [IDX_W-1:0]    cand_idx;
  logic                dist_we;
  logic [ADDR_W-1:0]   dist_wa;
  logic [DIST_W:0]     dist_wd;

  assign cand_idx = {s3_a_q, lane_id_i};
  assign cand_v   = s3_v_q && !s3_sel_q && ({1'b0, cand_idx} < count_i);

  always_comb begin
    dist_we = 1'b0;
    dist_wa = ctl_i.wr_addr;
    dist_wd = {1'b0, DIST_ONES};
    if (ctl_i.ld_we) begin
      dist_we = 1'b1;
    end else if (ctl_i.mk_we) begin
      dist_we = 1'b1;
      dist_wd = {1'b1, {DIST_W{1'b0}}};
    end else if (cand_v) begin
      dist_we = 1'b1;
      dist_wa = s3_a_q;
      dist_wd = {1'b0, s3_nd_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_we) begin
      pt_mem[ctl_i.wr_addr] <= wr_pt_i;
    end
    if (ctl_i.rd_en) begin
      pt_rd_q <= pt_mem[ctl_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    if (ctl_i.rd_en) begin
      dist_rd_q <= dist_mem[ctl_i.rd_addr];
    end
  end

  // Stage 1: per-axis difference and square.
  always_comb begin
    logic signed [COORD_W:0] diff;
    logic [COORD_W-1:0]      mag;
    for (int d = 0; d < 3; d++) begin
      diff = $signed({pt_rd_q[d*COORD_W + COORD_W-1], pt_rd_q[d*COORD_W +: COORD_W]})
           - $signed({ref_pt_i[d*COORD_W + COORD_W-1], ref_pt_i[d*COORD_W +: COORD_W]});
      mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
      sq_d[d] = mag * mag;
    end
  end

  // Stage 2: sum of squares and running minimum.
  assign sum_d = DIST_W'(sq_q[0]) + DIST_W'(sq_q[1]) + DIST_W'(sq_q[2]);
  assign nd_d  = (sum_d < s2_old_q[DIST_W-1:0]) ? sum_d : s2_old_q[DIST_W-1:0];

  always_ff @(posedge clk_i) begin
    sq_q     <= sq_d;
    s2_old_q <= dist_rd_q;
    s2_a_q   <= s1_a_q;
    s3_a_q   <= s2_a_q;
    s3_nd_q  <= nd_d;
    s3_sel_q <= s2_old_q[DIST_W];
    s1_a_q   <= ctl_i.rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= ctl_i.rd_en && ctl_i.sweep;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  assign rd_pt_o      = pt_rd_q;
  assign cand_o.valid = cand_v;
  assign cand_o.score = s3_nd_q;
  assign cand_o.idx   = cand_idx;

endmodule

// ===== hw/rtl/fps_merge.sv =====
module fps_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  fps_pkg::cand_t                cand_i [fps_pkg::LANES],
  output logic [fps_pkg::IDX_W-1:0]     best_idx_o
);
  import fps_pkg::*;

  cand_t best_q, best_d;
  cand_t step;

  always_comb begin
    step = '0;
    for (int l = 0; l < LANES; l++) begin
      if (cand_i[l].valid && (!step.valid || cand_i[l].score > step.score)) begin
        step = cand_i[l];
      end
    end
    best_d = best_q;
    if (clear_i) begin
      best_d = '0;
    end else if (step.valid && (!best_q.valid || step.score > best_q.score)) begin
      best_d = step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign best_idx_o = best_q.idx;

endmodule

// ===== hw/rtl/fps_checker.sv =====
module fps_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           last_point_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [fps_pkg::IDX_W-1:0]      sample_index_o,
  input logic                           last_sample_o,
  input logic                           start_error_o
);
  import fps_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_index_o))
    else $error("result item dropped before it was taken");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_error_o |-> last_sample_o && (sample_index_o == '0))
    else $error("start error item malformed");

  a_close_stops_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_point_i |=> !in_ready_o)
    else $error("intake open while a cloud is being sampled");

  a_load_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !last_point_i |=> in_ready_o)
    else $error("intake stalled in the middle of a cloud");

endmodule

bind farthest_point_sampler fps_checker u_fps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .last_point_i   (last_point_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sample_index_o (sample_index_o),
  .last_sample_o  (last_sample_o),
  .start_error_o  (start_error_o)
);

// ===== tb/testbench.sv =====
module testbench;
  import fps_pkg::*;

  // Records each point of the cloud under load that fits the store and, once
  // the closing point is accepted, works out the whole selection to be returned.
  class fps_scoreboard;
    typedef struct {
      logic [IDX_W-1:0] idx;
      logic             last;
      logic             err;
    } pick_t;

    pick_t                    picks_q[$];
    int                       errors;
    logic [SCNT_W-1:0]        samples_cfg;
    logic [IDX_W-1:0]         start_cfg;
    int                       n_pts;
    logic signed [COORD_W-1:0] px[MAX_POINTS];
    logic signed [COORD_W-1:0] py[MAX_POINTS];
    logic signed [COORD_W-1:0] pz[MAX_POINTS];

    function new();
      samples_cfg = 1;
      start_cfg   = 0;
      n_pts       = 0;
      errors      = 0;
    endfunction

    function void write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] d);
      if (r == REG_SAMPLE_COUNT) samples_cfg = d[SCNT_W-1:0];
      else start_cfg = d;
    endfunction

    function longint unsigned sq_dist(int a, int b);
      longint dx, dy, dz;
      dx = longint'(px[a]) - longint'(px[b]);
      dy = longint'(py[a]) - longint'(py[b]);
      dz = longint'(pz[a]) - longint'(pz[b]);
      return dx * dx + dy * dy + dz * dz;
    endfunction

    function void push_pick(int idx, bit last, bit err);
      pick_t p;
      p.idx  = IDX_W'(idx);
      p.last = last;
      p.err  = err;
      picks_q = {picks_q, p};
    endfunction

    function void note_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z, logic last_pt);
      int k, cur, best;
      longint unsigned d, best_d;
      longint unsigned nearest[MAX_POINTS];
      bit chosen[MAX_POINTS];
      bit found;
      // Points beyond the store size are dropped, but a closing one still closes the cloud.
      if (n_pts < MAX_POINTS) begin
        px[n_pts] = x;
        py[n_pts] = y;
        pz[n_pts] = z;
        n_pts++;
      end
      if (!last_pt) return;
      if (start_cfg >= n_pts) begin
        push_pick(0, 1'b1, 1'b1);
        n_pts = 0;
        return;
      end
      k = (samples_cfg == 0) ? 1 : (samples_cfg > MAX_SAMPLES) ? MAX_SAMPLES : samples_cfg;
      if (k > n_pts) k = n_pts;
      for (int p = 0; p < n_pts; p++) begin
        nearest[p] = {DIST_W{1'b1}};
        chosen[p]  = 1'b0;
      end
      cur = start_cfg;
      chosen[cur] = 1'b1;
      push_pick(cur, k == 1, 1'b0);
      for (int i = 1; i < k; i++) begin
        found  = 1'b0;
        best   = 0;
        best_d = 0;
        for (int p = 0; p < n_pts; p++) begin
          if (chosen[p]) continue;
          d = sq_dist(cur, p);
          if (d < nearest[p]) nearest[p] = d;
          // Strictly greater keeps the lowest index on ties.
          if (!found || nearest[p] > best_d) begin
            found  = 1'b1;
            best   = p;
            best_d = nearest[p];
          end
        end
        cur = best;
        chosen[cur] = 1'b1;
        push_pick(cur, i + 1 == k, 1'b0);
      end
      n_pts = 0;
    endfunction

    function void check_pick(logic [IDX_W-1:0] idx, logic last, logic err);
      pick_t e;
      if (picks_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: index %0d last %0b error %0b", idx, last, err);
        return;
      end
      e = picks_q.pop_front();
      if (idx !== e.idx || last !== e.last || err !== e.err) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected index %0d last %0b error %0b, got %0d %0b %0b",
                   e.idx, e.last, e.err, idx, last, err);
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic                      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] coord_x_i;
  logic signed [COORD_W-1:0] coord_y_i;
  logic signed [COORD_W-1:0] coord_z_i;
  logic                      last_point_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [IDX_W-1:0]          sample_index_o;
  logic                      last_sample_o;
  logic                      start_error_o;

  farthest_point_sampler DUT (.*);

  fps_scoreboard sb = new();

  // Sender burst state, the receiver's stall pattern and long hold-off request, points sent.
  int burst_left = 0;
  int hold_cycles = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int sent_items = 0;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // The run ends here if the block hangs; far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("FAIL farthest_point_sampler");
    $finish;
  end

  // Receiver: picks a new stall pattern each time the current one runs out, and when
  // asked holds ready low for a long stretch so the block backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: begin
          out_ready_i <= 1'b1;
        end
        1: begin
          out_ready_i <= $urandom_range(0, 1);
        end
        default: begin
          out_ready_i <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_pick(sample_index_o, last_sample_o, start_error_o);
  end

  task automatic write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(r, d);
    cfg_valid_i <= 1'b0;
  endtask

  // Offers one point; valid stays high across back-to-back items and is
  // lowered only when a gap between bursts follows.
  task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                            logic signed [COORD_W-1:0] z, logic last_pt);
    int gap;
    in_valid_i   <= 1'b1;
    coord_x_i    <= x;
    coord_y_i    <= y;
    coord_z_i    <= z;
    last_point_i <= last_pt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_point(x, y, z, last_pt);
    sent_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Withdraws the input, then waits until every expected index has come back
  // and the block is idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.picks_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // Sends a cloud of n points. Coordinate style: 0 full range, 1 a small box,
  // 2 a handful of repeated positions so distance ties are common.
  task automatic send_cloud(int n, int style);
    logic signed [COORD_W-1:0] x, y, z;
    for (int i = 0; i < n; i++) begin
      case (style)
        0: begin
          x = COORD_W'($urandom);
          y = COORD_W'($urandom);
          z = COORD_W'($urandom);
        end
        1: begin
          x = COORD_W'($urandom_range(0, 15) - 8);
          y = COORD_W'($urandom_range(0, 15) - 8);
          z = COORD_W'($urandom_range(0, 15) - 8);
        end
        default: begin
          x = COORD_W'(($urandom_range(0, 2) - 1) * 16'sd32767);
          y = $urandom_range(0, 1) ? 16'sh8000 : 16'sd0;
          z = 16'sd0;
        end
      endcase
      send_point(x, y, z, i == n - 1);
    end
  endtask

  initial begin
    int n, style;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_SAMPLE_COUNT;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    coord_x_i    = '0;
    coord_y_i    = '0;
    coord_z_i    = '0;
    last_point_i = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a single point under reset settings, with extreme coordinates.
    send_point(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1);
    drain();
    // Sample count zero acts as one.
    write_reg(REG_SAMPLE_COUNT, 10'd0);
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
    drain();
    // Start index equal to the point count gives the error item.
    write_reg(REG_START_INDEX, 10'd3);
    write_reg(REG_SAMPLE_COUNT, 10'd5);
    send_cloud(3, 0);
    drain();
    // Saturated sample count with the highest start index: error again.
    write_reg(REG_SAMPLE_COUNT, 10'h3ff);
    write_reg(REG_START_INDEX, 10'h3ff);
    send_cloud(4, 1);
    drain();
    // All points identical: the ties must resolve to the lowest index.
    write_reg(REG_START_INDEX, 10'd2);
    write_reg(REG_SAMPLE_COUNT, 10'd64);
    for (int i = 0; i < 6; i++) send_point(16'sd5, -16'sd5, 16'sd0, i == 5);
    drain();
    // Far corners: every selection lands on a distinct extreme.
    write_reg(REG_START_INDEX, 10'd0);
    send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 16'sd0, 1'b1);
    drain();

    // Random clouds, mostly small. Half of them reconfigure the block first,
    // the rest follow straight on so input backs up behind the selection.
    // The clouds right after the long receiver hold-off always follow on.
    for (int c = 0; sent_items < 360; c++) begin
      n     = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      if (n > 360 - sent_items) n = 360 - sent_items;
      style = $urandom_range(0, 2);
      if ((c < 3 || c > 4) && $urandom_range(0, 1)) begin
        drain();
        if ($urandom_range(0, 1))
          write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'($urandom_range(0, 1023)));
        else write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'($urandom_range(1, MAX_SAMPLES)));
        if ($urandom_range(0, 5) == 0)
          write_reg(REG_START_INDEX, CFG_DATA_W'($urandom_range(0, 1023)));
        else write_reg(REG_START_INDEX, CFG_DATA_W'($urandom_range(0, n - 1)));
      end
      if (c == 2) hold_cycles = 400;
      send_cloud(n, style);
    end
    in_valid_i <= 1'b0;
    drain();

    if (sb.errors == 0 && sb.picks_q.size() == 0) begin
      $display("PASS farthest_point_sampler");
    end else begin
      $display("FAIL farthest_point_sampler");
    end
    $finish;
  end

endmodule

// ===== farthest_point_sampler.f =====
hw/rtl/fps_pkg.sv
hw/rtl/fps_lane.sv
hw/rtl/fps_merge.sv
hw/rtl/farthest_point_sampler.sv
hw/rtl/fps_checker.sv
tb/testbench.sv
